/* src/mbrip_pkg.sv */
// Shared types, constants and CRC helpers for the inverter poller.
package mbrip_pkg;

  // Sizing defaults
  localparam int PAYLOAD_BYTES_DEF = 64;
  localparam int QUEUE_DEPTH_DEF   = 4;
  localparam int CFG_IDX_W         = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT    = 1'b1;

  // Modbus constants
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
  localparam int          MAIN_START      = 3000;
  localparam int          TEMP_START      = 3042;
  localparam logic [15:0] MAIN_START_M1   = 16'(MAIN_START - 1);
  localparam logic [15:0] TEMP_START_M1   = 16'(TEMP_START - 1);
  localparam logic [15:0] MAIN_COUNT      = 16'd26;
  localparam logic [15:0] TEMP_COUNT      = 16'd1;

  // Result kinds
  localparam logic [1:0] KIND_TX    = 2'd0;
  localparam logic [1:0] KIND_MAIN  = 2'd1;
  localparam logic [1:0] KIND_TEMP  = 2'd2;
  localparam logic [1:0] KIND_NORSP = 2'd3;

  // Job codes carried from front to back
  localparam logic [1:0] JOB_POLL = 2'd0;
  localparam logic [1:0] JOB_MAIN = 2'd1;
  localparam logic [1:0] JOB_TEMP = 2'd2;

  // Payload bytes that ever reach a record, and their slots
  localparam int PICK_COUNT = 18;
  localparam logic [7:0] PICK_POS [PICK_COUNT] = '{
    8'd0,  8'd1,  8'd12, 8'd13, 8'd18, 8'd19, 8'd20, 8'd21, 8'd30,
    8'd31, 8'd44, 8'd45, 8'd46, 8'd47, 8'd48, 8'd49, 8'd50, 8'd51
  };
  localparam int SL_TEMP   = 0;
  localparam int SL_POWER  = 2;
  localparam int SL_ETOTAL = 4;
  localparam int SL_ETODAY = 8;
  localparam int SL_DC1V   = 10;
  localparam int SL_DC1C   = 12;
  localparam int SL_DC2V   = 14;
  localparam int SL_DC2C   = 16;

  typedef logic [PICK_COUNT-1:0][7:0] pick_t;

  typedef struct packed {
    logic [1:0] code;
    logic       miss;      // no-response record goes ahead of the request
    logic       temp_blk;  // request targets the temperature block
    logic [7:0] addr;
    pick_t      pick;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [15:0] active_power;
    logic [15:0] dc1_voltage;
    logic [15:0] dc1_current;
    logic [15:0] dc2_voltage;
    logic [15:0] dc2_current;
    logic [31:0] energy_total;
    logic [15:0] energy_today;
    logic [15:0] temperature;
  } res_t;

  // One byte through the reflected CRC-16
  function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  // Request header bytes 0..5
  function automatic logic [7:0] req_byte(input logic [7:0] addr, input logic temp_blk,
                                          input logic [2:0] i);
    logic [15:0] start_m1;
    logic [15:0] count;
    logic [7:0]  b;
    start_m1 = temp_blk ? TEMP_START_M1 : MAIN_START_M1;
    count    = temp_blk ? TEMP_COUNT : MAIN_COUNT;
    case (i)
      3'd0:    b = addr;
      3'd1:    b = FUNC_READ_INPUT;
      3'd2:    b = start_m1[15:8];
      3'd3:    b = start_m1[7:0];
      3'd4:    b = count[15:8];
      3'd5:    b = count[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [15:0] word16(input pick_t p, input int s);
    return {p[s], p[s+1]};
  endfunction

endpackage

/* src/mbrip_if.sv */
// Valid/ready channel interfaces for input items and results.
interface mbrip_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;
  logic       after_silence;

  modport source (output valid, op, rx_byte, after_silence, input ready);
  modport sink   (input valid, op, rx_byte, after_silence, output ready);
endinterface

interface mbrip_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic [15:0] active_power;
  logic [15:0] dc1_voltage;
  logic [15:0] dc1_current;
  logic [15:0] dc2_voltage;
  logic [15:0] dc2_current;
  logic [31:0] energy_total;
  logic [15:0] energy_today;
  logic [15:0] temperature;

  modport source (output valid, kind, tx_byte, last, active_power, dc1_voltage, dc1_current,
                  dc2_voltage, dc2_current, energy_total, energy_today, temperature,
                  input ready);
  modport sink   (input valid, kind, tx_byte, last, active_power, dc1_voltage, dc1_current,
                  dc2_voltage, dc2_current, energy_total, energy_today, temperature,
                  output ready);
endinterface

/* src/modbus_rtu_inverter_poller.sv */
// Top level of the Modbus RTU read-input-registers poller for one inverter.
//
// Input channel "items": each transfer is a received line byte (op = 0) or a
// poll tick (op = 1). A poll tick yields the 9-byte request frame as tx-byte
// results, preceded by a zero-power no-response record once miss_limit ticks
// pass with no byte in between. A received byte that closes a frame with a
// good CRC yields one main or temperature record.
// Configuration: cfg_we with cfg_index 0 (slave address) or 1 (miss limit).
// Path: with the queue empty, an item's first result passes the job queue
// and then the output register. Throughput: the front takes one item per
// cycle while the queue has room; the back sends one result per cycle while
// results.ready is high, so a poll tick holds the back for 9 or 10 results. The
// job queue (QUEUE_DEPTH entries) absorbs bytes; items.ready falls when it fills.
// A stalled results channel holds its output register and backs up the queue.
// Reset: parser idle, no block requested, miss count zero, captured payload
// zero, registers to address 1 and limit 10, queue empty, no result valid.
module modbus_rtu_inverter_poller
  import mbrip_pkg::*;
#(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  mbrip_in_if.sink             items,
  mbrip_out_if.source          results
);

  push_t push;
  logic  q_full;
  logic  head_valid;
  job_t  head;
  logic  pop;

  // Parser and poll bookkeeping
  mbrip_front #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items),
    .q_full    (q_full),
    .push      (push)
  );

  // Job queue
  mbrip_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // Result sequencer
  mbrip_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .results    (results)
  );

`ifndef SYNTHESIS
  // A poll tick always leaves a job waiting
  a_poll_queued: assert property (@(posedge clk) disable iff (rst)
    items.valid && items.ready && items.op |=> head_valid)
    else $error("poll tick did not queue a job");

  // The request follows straight after a no-response record
  a_norsp_then_tx: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.ready && results.kind == KIND_NORSP
    |=> results.valid && results.kind == KIND_TX)
    else $error("no request byte after no-response record");

  // No-response record never closes an item
  a_norsp_not_last: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.kind == KIND_NORSP |-> !results.last)
    else $error("no-response record marked last");

  // Data records are single results
  a_record_last: assert property (@(posedge clk) disable iff (rst)
    results.valid && (results.kind == KIND_MAIN || results.kind == KIND_TEMP)
    |-> results.last)
    else $error("data record not marked last");
`endif

endmodule

/* src/mbrip_front.sv */
// Front end: config registers, poll bookkeeping and response frame parser.
module mbrip_front
  import mbrip_pkg::*;
#(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  mbrip_in_if.sink             items,
  input  logic                 q_full,
  output push_t                push
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_HEAD = 3'd1;
  localparam logic [2:0] PH_FUNC = 3'd2;
  localparam logic [2:0] PH_LEN  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_CRC1 = 3'd5;
  localparam logic [2:0] PH_CRC2 = 3'd6;

  localparam logic [1:0] BLK_NONE = 2'd0;
  localparam logic [1:0] BLK_MAIN = 2'd1;
  localparam logic [1:0] BLK_TEMP = 2'd2;

  localparam logic [7:0] LEN_LIMIT = 8'(PAYLOAD_BYTES);

  logic [7:0]  slave_address;
  logic [3:0]  miss_limit;
  logic [2:0]  phase, phase_next, phase_eff;
  logic [15:0] crc, crc_next, crc_fed;
  logic [7:0]  plen, plen_next;
  logic [7:0]  pidx, pidx_next, pidx_inc;
  logic [1:0]  block, block_next;
  logic [3:0]  miss_count, miss_count_next, miss_inc;
  pick_t       pick;
  logic        accept, head_match, data_we;

  assign items.ready = !q_full;
  assign accept      = items.valid && !q_full;

  // Silence restarts a frame that is in progress
  assign phase_eff  = (items.after_silence && phase != PH_IDLE) ? PH_HEAD : phase;
  assign head_match = (phase_eff == PH_HEAD) && (items.rx_byte == slave_address);
  assign crc_fed    = crc_feed(head_match ? CRC_INIT : crc, items.rx_byte);
  assign pidx_inc   = pidx + 8'd1;
  assign miss_inc   = miss_count + 4'd1;

  // Next state and job classification
  always_comb begin
    phase_next      = phase;
    crc_next        = crc;
    plen_next       = plen;
    pidx_next       = pidx;
    block_next      = block;
    miss_count_next = miss_count;
    data_we         = 1'b0;
    push.valid         = 1'b0;
    push.job.code      = JOB_POLL;
    push.job.miss      = 1'b0;
    push.job.temp_blk  = (block == BLK_MAIN);
    push.job.addr      = slave_address;
    push.job.pick      = pick;
    if (accept) begin
      if (items.op) begin
        // poll tick: count the miss, toggle the block, send a request
        if (miss_count < miss_limit) begin
          miss_count_next = miss_inc;
          push.job.miss   = (miss_inc >= miss_limit);
        end
        block_next = (block != BLK_MAIN) ? BLK_MAIN : BLK_TEMP;
        phase_next = PH_HEAD;
        push.valid = 1'b1;
      end else begin
        miss_count_next = 4'd0;
        crc_next        = crc_fed;
        unique case (phase_eff)
          PH_HEAD: begin
            if (head_match) phase_next = PH_FUNC;
            else            phase_next = PH_HEAD;
          end
          PH_FUNC: begin
            phase_next = (items.rx_byte == FUNC_READ_INPUT) ? PH_LEN : PH_IDLE;
          end
          PH_LEN: begin
            if (items.rx_byte < LEN_LIMIT) begin
              plen_next  = items.rx_byte;
              pidx_next  = 8'd0;
              phase_next = (items.rx_byte == 8'd0) ? PH_CRC1 : PH_DATA;
            end else begin
              phase_next = PH_IDLE;
            end
          end
          PH_DATA: begin
            data_we   = 1'b1;
            pidx_next = pidx_inc;
            if (pidx_inc >= plen) phase_next = PH_CRC1;
          end
          PH_CRC1: begin
            phase_next = PH_CRC2;
          end
          PH_CRC2: begin
            // good residue hands a record of the last requested block
            if (crc_fed == 16'h0000 && block != BLK_NONE) begin
              push.valid    = 1'b1;
              push.job.code = (block == BLK_MAIN) ? JOB_MAIN : JOB_TEMP;
            end
            phase_next = PH_IDLE;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'd1;
      miss_limit    <= 4'd10;
      phase         <= PH_IDLE;
      crc           <= CRC_INIT;
      plen          <= 8'd0;
      pidx          <= 8'd0;
      block         <= BLK_NONE;
      miss_count    <= 4'd0;
    end else begin
      phase      <= phase_next;
      crc        <= crc_next;
      plen       <= plen_next;
      pidx       <= pidx_next;
      block      <= block_next;
      miss_count <= miss_count_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLAVE_ADDRESS: slave_address <= cfg_data;
          CFG_MISS_LIMIT:    miss_limit    <= cfg_data[3:0];
          default:           ;
        endcase
      end
    end
  end

  // Captured payload bytes; reset reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      pick <= '0;
    end else begin
      for (int k = 0; k < PICK_COUNT; k++) begin
        if (data_we && pidx == PICK_POS[k]) pick[k] <= items.rx_byte;
      end
    end
  end

endmodule

/* src/mbrip_queue.sv */
// Short job queue between the parser and the result sequencer.
module mbrip_queue
  import mbrip_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  full,
  output logic  head_valid,
  output job_t  head,
  input  logic  pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;
  logic          do_push, do_pop;

  assign full       = (count == (PW+1)'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head_valid;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  // Job storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push.job;
  end

endmodule

/* src/mbrip_back.sv */
// Back end: expands jobs into result items behind an output register.
module mbrip_back
  import mbrip_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  job_t      head,
  output logic      pop,
  mbrip_out_if.source results
);

  localparam logic [3:0] POS_NORSP  = 4'd0;
  localparam logic [3:0] POS_TX0    = 4'd1;
  localparam logic [3:0] POS_TX1    = 4'd2;
  localparam logic [3:0] POS_TX2    = 4'd3;
  localparam logic [3:0] POS_TX3    = 4'd4;
  localparam logic [3:0] POS_TX4    = 4'd5;
  localparam logic [3:0] POS_TX5    = 4'd6;
  localparam logic [3:0] POS_CRCLO  = 4'd7;
  localparam logic [3:0] POS_CRCHI  = 4'd8;
  localparam logic [3:0] POS_TXLAST = 4'd9;

  logic        ovalid;
  res_t        ores, res_n;
  logic [3:0]  pos, cur_p;
  logic [2:0]  tx_i;
  logic [15:0] crc, crc_fed;
  logic [7:0]  tx_val;
  logic        load, hdr_byte;

  assign load  = head_valid && (!ovalid || results.ready);
  assign cur_p = (pos == POS_NORSP && !head.miss) ? POS_TX0 : pos;
  assign tx_i  = 3'(cur_p - POS_TX0);

  // Request byte for the current position
  always_comb begin
    hdr_byte = 1'b0;
    case (cur_p) inside
      POS_TX0, POS_TX1, POS_TX2, POS_TX3, POS_TX4, POS_TX5: begin
        hdr_byte = 1'b1;
        tx_val   = req_byte(head.addr, head.temp_blk, tx_i);
      end
      POS_CRCLO: tx_val = crc[7:0];
      POS_CRCHI: tx_val = crc[15:8];
      default:   tx_val = 8'h00;
    endcase
  end

  assign crc_fed = crc_feed((cur_p == POS_TX0) ? CRC_INIT : crc, tx_val);

  // Result item and dequeue
  always_comb begin
    res_n = '0;
    pop   = 1'b0;
    unique case (head.code)
      JOB_POLL: begin
        if (cur_p == POS_NORSP) begin
          res_n.kind = KIND_NORSP;
        end else begin
          res_n.kind    = KIND_TX;
          res_n.tx_byte = tx_val;
          res_n.last    = (cur_p == POS_TXLAST);
        end
        pop = load && (cur_p == POS_TXLAST);
      end
      JOB_MAIN: begin
        res_n.kind         = KIND_MAIN;
        res_n.last         = 1'b1;
        res_n.active_power = word16(head.pick, SL_POWER);
        res_n.dc1_voltage  = word16(head.pick, SL_DC1V);
        res_n.dc1_current  = word16(head.pick, SL_DC1C);
        res_n.dc2_voltage  = word16(head.pick, SL_DC2V);
        res_n.dc2_current  = word16(head.pick, SL_DC2C);
        res_n.energy_total = {word16(head.pick, SL_ETOTAL), word16(head.pick, SL_ETOTAL + 2)};
        res_n.energy_today = word16(head.pick, SL_ETODAY);
        pop = load;
      end
      JOB_TEMP: begin
        res_n.kind        = KIND_TEMP;
        res_n.last        = 1'b1;
        res_n.temperature = word16(head.pick, SL_TEMP);
        pop = load;
      end
      default: begin
        pop = load;
      end
    endcase
  end

  // Sequencer position, request CRC and valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      pos    <= POS_NORSP;
      crc    <= CRC_INIT;
    end else begin
      if (load) begin
        ovalid <= 1'b1;
        if (head.code == JOB_POLL) begin
          pos <= (cur_p == POS_TXLAST) ? POS_NORSP : cur_p + 4'd1;
          if (hdr_byte) crc <= crc_fed;
        end
      end else if (results.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) ores <= res_n;
  end

  assign results.valid        = ovalid;
  assign results.kind         = ores.kind;
  assign results.tx_byte      = ores.tx_byte;
  assign results.last         = ores.last;
  assign results.active_power = ores.active_power;
  assign results.dc1_voltage  = ores.dc1_voltage;
  assign results.dc1_current  = ores.dc1_current;
  assign results.dc2_voltage  = ores.dc2_voltage;
  assign results.dc2_current  = ores.dc2_current;
  assign results.energy_total = ores.energy_total;
  assign results.energy_today = ores.energy_today;
  assign results.temperature  = ores.temperature;

endmodule
